// ----- hdl/bgf_pkg.sv -----
package bgf_pkg;

   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 256;

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int SIZE_W  = 9;
   localparam int LIMIT_W = 9;
   localparam int DIST_W  = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
   localparam int SUM_W   = (DIST_W > LIMIT_W ? DIST_W : LIMIT_W) + 1;

   localparam logic [SIZE_W-1:0]  COLS_RESET  = SIZE_W'(MAX_COLS);
   localparam logic [SIZE_W-1:0]  ROWS_RESET  = SIZE_W'(MAX_ROWS);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      DIR_CENTER,
      DIR_LEFT,
      DIR_RIGHT,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  cols;
      logic [SIZE_W-1:0]  rows;
      logic [LIMIT_W-1:0] hlimit;
      logic [LIMIT_W-1:0] vlimit;
   } cfg_type;

   typedef struct packed {
      logic    clear;
      logic    write;
      logic    capture;
      dir_type dir;
      logic    dist_load;
      logic    dist_step;
      logic    save_a;
      logic    set_h;
      logic    set_v;
      logic    flag;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      logic pixel;
      logic in_frame;
      logic col_first;
      logic col_last;
      logic row_first;
      logic row_last;
      logic edge_hit;
      logic far;
      logic in_limit;
      logic clear_done;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/bgf_csr.sv -----
module bgf_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output bgf_pkg::cfg_type           cfg
);

   localparam logic [1:0] REG_COLS   = 2'd0;
   localparam logic [1:0] REG_ROWS   = 2'd1;
   localparam logic [1:0] REG_HLIMIT = 2'd2;
   localparam logic [1:0] REG_VLIMIT = 2'd3;

   bgf_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   function automatic logic [bgf_pkg::SIZE_W-1:0] clamp_size(
      input logic [bgf_pkg::SIZE_W-1:0] v,
      input logic [bgf_pkg::SIZE_W-1:0] maxv
   );
      logic [bgf_pkg::SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = bgf_pkg::SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_COLS: begin
               cfg_in.cols = clamp_size(csr_pwdata[bgf_pkg::SIZE_W-1:0],
                                        bgf_pkg::COLS_RESET);
            end
            REG_ROWS: begin
               cfg_in.rows = clamp_size(csr_pwdata[bgf_pkg::SIZE_W-1:0],
                                        bgf_pkg::ROWS_RESET);
            end
            REG_HLIMIT: cfg_in.hlimit = csr_pwdata[bgf_pkg::LIMIT_W-1:0];
            REG_VLIMIT: cfg_in.vlimit = csr_pwdata[bgf_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COLS:   csr_prdata = 32'(cfg_ff.cols);
         REG_ROWS:   csr_prdata = 32'(cfg_ff.rows);
         REG_HLIMIT: csr_prdata = 32'(cfg_ff.hlimit);
         REG_VLIMIT: csr_prdata = 32'(cfg_ff.vlimit);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols   <= bgf_pkg::COLS_RESET;
         cfg_ff.rows   <= bgf_pkg::ROWS_RESET;
         cfg_ff.hlimit <= bgf_pkg::LIMIT_RESET;
         cfg_ff.vlimit <= bgf_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      (cfg_ff.cols != '0) && (cfg_ff.cols <= bgf_pkg::COLS_RESET) &&
      (cfg_ff.rows != '0) && (cfg_ff.rows <= bgf_pkg::ROWS_RESET))
      else $error("frame size register out of range");

endmodule

// ----- hdl/bgf_datapath.sv -----
module bgf_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bgf_pkg::ROW_W-1:0]   req_row,
   input  logic [bgf_pkg::COL_W-1:0]   req_col,
   input  logic                        req_pixel_set,
   input  bgf_pkg::cfg_type            cfg,
   input  bgf_pkg::cmd_type            cmd,
   output bgf_pkg::status_type         status,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_filled,
   output logic                        rsp_horizontal_filled,
   output logic                        rsp_vertical_filled,
   output logic [bgf_pkg::ROW_W-1:0]   rsp_query_row,
   output logic [bgf_pkg::COL_W-1:0]   rsp_query_col
);

   localparam int DEPTH = bgf_pkg::MAX_ROWS * bgf_pkg::MAX_COLS;

   logic                          mem [0:DEPTH-1];
   logic                          rd_ff;

   logic [bgf_pkg::ADDR_W-1:0]    clr_ff, clr_in;
   logic [bgf_pkg::ROW_W-1:0]     row_ff;
   logic [bgf_pkg::COL_W-1:0]     col_ff;
   logic [bgf_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic [bgf_pkg::DIST_W-1:0]    a_ff;
   bgf_pkg::dir_type              dir_ff;
   logic                          h_ff, v_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_filled_ff, rsp_h_ff, rsp_v_ff;
   logic [bgf_pkg::ROW_W-1:0]     rsp_row_ff;
   logic [bgf_pkg::COL_W-1:0]     rsp_col_ff;

   logic [bgf_pkg::ROW_W-1:0]     probe_row;
   logic [bgf_pkg::COL_W-1:0]     probe_col;
   logic                          req_inside;
   logic                          mem_we;
   logic [bgf_pkg::ADDR_W-1:0]    mem_waddr;
   logic                          mem_wdata;

   logic [bgf_pkg::SUM_W-1:0]     sum;
   logic [bgf_pkg::SUM_W-1:0]     limit;
   logic [bgf_pkg::SUM_W-1:0]     col_w, row_w, dist_w;
   logic                          edge_hit;

   // Distance counter
   always_comb begin
      dist_in = dist_ff;
      if (cmd.dist_load) begin
         dist_in = bgf_pkg::DIST_W'(1);
      end else if (cmd.dist_step) begin
         dist_in = dist_ff + bgf_pkg::DIST_W'(1);
      end
   end

   // Probe address for the read issued at this edge
   always_comb begin
      probe_row = row_ff;
      probe_col = col_ff;
      case (cmd.dir)
         bgf_pkg::DIR_LEFT:  probe_col = col_ff - dist_in[bgf_pkg::COL_W-1:0];
         bgf_pkg::DIR_RIGHT: probe_col = col_ff + dist_in[bgf_pkg::COL_W-1:0];
         bgf_pkg::DIR_UP:    probe_row = row_ff - dist_in[bgf_pkg::ROW_W-1:0];
         bgf_pkg::DIR_DOWN:  probe_row = row_ff + dist_in[bgf_pkg::ROW_W-1:0];
         default: begin
            probe_row = row_ff;
            probe_col = col_ff;
         end
      endcase
   end

   assign req_inside = ({1'b0, req_row} < cfg.rows) && ({1'b0, req_col} < cfg.cols);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {req_row, req_col};
      mem_wdata = req_pixel_set;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = 1'b0;
      end else if (cmd.write && req_inside) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[{probe_row, probe_col}];
   end

   assign clr_in = cmd.clear ? clr_ff + bgf_pkg::ADDR_W'(1) : clr_ff;

   // Gap arithmetic for the pixel held in rd_ff
   assign col_w  = bgf_pkg::SUM_W'(col_ff);
   assign row_w  = bgf_pkg::SUM_W'(row_ff);
   assign dist_w = bgf_pkg::SUM_W'(dist_ff);

   always_comb begin
      sum      = dist_w;
      limit    = bgf_pkg::SUM_W'(cfg.hlimit);
      edge_hit = 1'b0;
      case (dir_ff)
         bgf_pkg::DIR_LEFT: begin
            edge_hit = (dist_w == col_w);
         end
         bgf_pkg::DIR_RIGHT: begin
            sum = bgf_pkg::SUM_W'(a_ff) + dist_w;
            edge_hit = (col_w + dist_w + bgf_pkg::SUM_W'(1)) ==
                       bgf_pkg::SUM_W'(cfg.cols);
         end
         bgf_pkg::DIR_UP: begin
            limit = bgf_pkg::SUM_W'(cfg.vlimit);
            edge_hit = (dist_w == row_w);
         end
         bgf_pkg::DIR_DOWN: begin
            sum   = bgf_pkg::SUM_W'(a_ff) + dist_w;
            limit = bgf_pkg::SUM_W'(cfg.vlimit);
            edge_hit = (row_w + dist_w + bgf_pkg::SUM_W'(1)) ==
                       bgf_pkg::SUM_W'(cfg.rows);
         end
         default: edge_hit = 1'b0;
      endcase
   end

   assign status.edge_hit   = edge_hit;
   assign status.pixel      = rd_ff;
   assign status.far        = (sum + bgf_pkg::SUM_W'(1)) >= limit;
   assign status.in_limit   = sum < limit;
   assign status.in_frame   = ({1'b0, row_ff} < cfg.rows) && ({1'b0, col_ff} < cfg.cols);
   assign status.col_first  = (col_ff == '0);
   assign status.row_first  = (row_ff == '0);
   assign status.col_last   = ({1'b0, col_ff} + bgf_pkg::SIZE_W'(1)) == cfg.cols;
   assign status.row_last   = ({1'b0, row_ff} + bgf_pkg::SIZE_W'(1)) == cfg.rows;
   assign status.clear_done = (clr_ff == '1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         dir_ff       <= bgf_pkg::DIR_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         dir_ff <= cmd.dir;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
         h_ff   <= 1'b0;
         v_ff   <= 1'b0;
      end else begin
         if (cmd.set_h) begin
            h_ff <= cmd.flag;
         end
         if (cmd.set_v) begin
            v_ff <= cmd.flag;
         end
      end
      if (cmd.save_a) begin
         a_ff <= dist_ff;
      end
      if (cmd.emit) begin
         rsp_filled_ff <= h_ff && v_ff;
         rsp_h_ff      <= h_ff;
         rsp_v_ff      <= v_ff;
         rsp_row_ff    <= row_ff;
         rsp_col_ff    <= col_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_filled            = rsp_filled_ff;
   assign rsp_horizontal_filled = rsp_h_ff;
   assign rsp_vertical_filled   = rsp_v_ff;
   assign rsp_query_row         = rsp_row_ff;
   assign rsp_query_col         = rsp_col_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while held");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      (dir_ff == bgf_pkg::DIR_LEFT) |-> (dist_w <= col_w))
      else $error("left scan passed column zero");

   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !(cmd.write || cmd.capture || cmd.emit))
      else $error("item taken during clear pass");

endmodule

// ----- hdl/bgf_ctrl.sv -----
module bgf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_ready,
   input  bgf_pkg::status_type   status,
   output bgf_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      ISSUE,
      CENTER,
      LEFT,
      RIGHT,
      VSTART,
      UP,
      DOWN,
      DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.dir   = bgf_pkg::DIR_CENTER;
      unique case (state_ff)
         CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == bgf_pkg::KIND_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ISSUE;
               end
            end
         end
         ISSUE: begin
            state_in = status.in_frame ? CENTER : DONE;
         end
         CENTER: begin
            if (status.pixel) begin
               cmd.set_h = 1'b1;
               cmd.set_v = 1'b1;
               cmd.flag  = 1'b1;
               state_in  = DONE;
            end else if (status.col_first) begin
               state_in = VSTART;
            end else begin
               cmd.dir       = bgf_pkg::DIR_LEFT;
               cmd.dist_load = 1'b1;
               state_in      = LEFT;
            end
         end
         LEFT: begin
            if (status.pixel) begin
               if (status.far || status.col_last) begin
                  state_in = VSTART;
               end else begin
                  cmd.save_a    = 1'b1;
                  cmd.dir       = bgf_pkg::DIR_RIGHT;
                  cmd.dist_load = 1'b1;
                  state_in      = RIGHT;
               end
            end else if (status.edge_hit || status.far) begin
               state_in = VSTART;
            end else begin
               cmd.dir       = bgf_pkg::DIR_LEFT;
               cmd.dist_step = 1'b1;
            end
         end
         RIGHT: begin
            if (status.pixel) begin
               cmd.set_h = 1'b1;
               cmd.flag  = status.in_limit;
               state_in  = VSTART;
            end else if (status.edge_hit || status.far) begin
               state_in = VSTART;
            end else begin
               cmd.dir       = bgf_pkg::DIR_RIGHT;
               cmd.dist_step = 1'b1;
            end
         end
         VSTART: begin
            if (status.row_first) begin
               state_in = DONE;
            end else begin
               cmd.dir       = bgf_pkg::DIR_UP;
               cmd.dist_load = 1'b1;
               state_in      = UP;
            end
         end
         UP: begin
            if (status.pixel) begin
               if (status.far || status.row_last) begin
                  state_in = DONE;
               end else begin
                  cmd.save_a    = 1'b1;
                  cmd.dir       = bgf_pkg::DIR_DOWN;
                  cmd.dist_load = 1'b1;
                  state_in      = DOWN;
               end
            end else if (status.edge_hit || status.far) begin
               state_in = DONE;
            end else begin
               cmd.dir       = bgf_pkg::DIR_UP;
               cmd.dist_step = 1'b1;
            end
         end
         DOWN: begin
            if (status.pixel) begin
               cmd.set_v = 1'b1;
               cmd.flag  = status.in_limit;
               state_in  = DONE;
            end else if (status.edge_hit || status.far) begin
               state_in = DONE;
            end else begin
               cmd.dir       = bgf_pkg::DIR_DOWN;
               cmd.dist_step = 1'b1;
            end
         end
         DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/binary_gap_fill_run_length_top.sv -----
// Binary gap filler over a stored one-bit frame of up to 256 x 256 pixels.
// Request channel (req_*): req_kind selects a pixel write or a query at
// req_row/req_col; a write stores req_pixel_set when inside the frame size
// in use, else it is dropped. A write gives no result.
// Result channel (rsp_*): one transfer per query with the filled mask bit,
// the horizontal and vertical partial tests and the echoed coordinates.
// A query probes one stored pixel per cycle: first the center pixel, then
// the pixels scanned left, right, up and down, with a step to start the
// vertical scan and a last step to load the result register.
// Each scan stops at the first set pixel, the frame edge or once the gap
// limit can no longer be met. No request is taken until the query's
// result is in the output register. After reset the pixel memory is
// cleared one pixel per cycle while req_ready is low; CSR writes are
// taken as ever.
// A finished result waits in the output register while the receiver
// stalls; the next item is accepted meanwhile, and a following query holds
// its result until the register is free.
// CSR map (csr_*): 0x0 cols_in_use, 0x4 rows_in_use, 0x8 horizontal limit,
// 0xC vertical limit.
module binary_gap_fill_run_length_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [bgf_pkg::ROW_W-1:0]   req_row,
   input  logic [bgf_pkg::COL_W-1:0]   req_col,
   input  logic                        req_pixel_set,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_filled,
   output logic                        rsp_horizontal_filled,
   output logic                        rsp_vertical_filled,
   output logic [bgf_pkg::ROW_W-1:0]   rsp_query_row,
   output logic [bgf_pkg::COL_W-1:0]   rsp_query_col,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   bgf_pkg::cfg_type    cfg;
   bgf_pkg::cmd_type    cmd;
   bgf_pkg::status_type status;

   bgf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bgf_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_row               (req_row),
      .req_col               (req_col),
      .req_pixel_set         (req_pixel_set),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .status                (status),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_filled            (rsp_filled),
      .rsp_horizontal_filled (rsp_horizontal_filled),
      .rsp_vertical_filled   (rsp_vertical_filled),
      .rsp_query_row         (rsp_query_row),
      .rsp_query_col         (rsp_query_col)
   );

endmodule

// ----- sim/binary_gap_fill_run_length_top_tb.sv -----
module binary_gap_fill_run_length_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 32;
   localparam int unsigned ITEM_TARGET  = 1050;

   typedef enum int {
      CSR_COLS,
      CSR_ROWS,
      CSR_HLIMIT,
      CSR_VLIMIT
   } csr_index_type;

   typedef struct packed {
      logic                      filled;
      logic                      horizontal;
      logic                      vertical;
      logic [bgf_pkg::ROW_W-1:0] row;
      logic [bgf_pkg::COL_W-1:0] col;
   } mask_answer_type;

   class fill_mask_tracker_type;
      bit              frame [bgf_pkg::MAX_ROWS][bgf_pkg::MAX_COLS];
      int unsigned     cols_used;
      int unsigned     rows_used;
      int unsigned     hlimit;
      int unsigned     vlimit;
      mask_answer_type pending_answers[$];
      int              errors;

      function new();
         cols_used = bgf_pkg::MAX_COLS;
         rows_used = bgf_pkg::MAX_ROWS;
         hlimit    = 100;
         vlimit    = 100;
         errors    = 0;
      endfunction

      function int unsigned clamp_extent(logic [31:0] value, int unsigned top);
         int unsigned v;
         v = value & 32'h1FF;
         if (v == 0)
            return 1;
         if (v > top)
            return top;
         return v;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_COLS:   cols_used = clamp_extent(value, bgf_pkg::MAX_COLS);
            CSR_ROWS:   rows_used = clamp_extent(value, bgf_pkg::MAX_ROWS);
            CSR_HLIMIT: hlimit = value & 32'h1FF;
            CSR_VLIMIT: vlimit = value & 32'h1FF;
            default: ;
         endcase
      endfunction

      function bit gap_closes(bit vertical, int fixed, int pos, int len, int limit);
         int lo;
         int hi;
         bit found_lo;
         bit found_hi;
         lo       = pos;
         hi       = pos;
         found_lo = 1'b0;
         found_hi = 1'b0;
         while (lo > 0 && !found_lo) begin
            lo = lo - 1;
            found_lo = vertical ? frame[lo][fixed] : frame[fixed][lo];
         end
         while (hi + 1 < len && !found_hi) begin
            hi = hi + 1;
            found_hi = vertical ? frame[hi][fixed] : frame[fixed][hi];
         end
         return found_lo && found_hi && ((hi - lo) < limit);
      endfunction

      function void take_request(logic kind, logic [bgf_pkg::ROW_W-1:0] row,
                                 logic [bgf_pkg::COL_W-1:0] col, logic pixel);
         mask_answer_type ans;
         bit              in_frame;
         in_frame = (row < rows_used) && (col < cols_used);
         if (kind == bgf_pkg::KIND_WRITE) begin
            if (in_frame)
               frame[row][col] = pixel;
            return;
         end
         ans     = '0;
         ans.row = row;
         ans.col = col;
         if (in_frame) begin
            if (frame[row][col]) begin
               ans.horizontal = 1'b1;
               ans.vertical   = 1'b1;
            end else begin
               ans.horizontal = gap_closes(1'b0, row, col, cols_used, hlimit);
               ans.vertical   = gap_closes(1'b1, col, row, rows_used, vlimit);
            end
         end
         ans.filled = ans.horizontal & ans.vertical;
         pending_answers = {pending_answers, ans};
      endfunction

      function void report_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_answer(mask_answer_type got);
         mask_answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                     $time, got.row, got.col);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         report_field("filled", want.filled, got.filled);
         report_field("horizontal_filled", want.horizontal, got.horizontal);
         report_field("vertical_filled", want.vertical, got.vertical);
         report_field("query_row", want.row, got.row);
         report_field("query_col", want.col, got.col);
      endfunction
   endclass

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_ready;
   logic                      req_kind      = bgf_pkg::KIND_WRITE;
   logic [bgf_pkg::ROW_W-1:0] req_row       = '0;
   logic [bgf_pkg::COL_W-1:0] req_col       = '0;
   logic                      req_pixel_set = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready     = 1'b0;
   logic                      rsp_filled;
   logic                      rsp_horizontal_filled;
   logic                      rsp_vertical_filled;
   logic [bgf_pkg::ROW_W-1:0] rsp_query_row;
   logic [bgf_pkg::COL_W-1:0] rsp_query_col;
   logic                      csr_psel      = 1'b0;
   logic                      csr_penable   = 1'b0;
   logic                      csr_pwrite    = 1'b0;
   logic [3:0]                csr_paddr     = '0;
   logic [31:0]               csr_pwdata    = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   fill_mask_tracker_type tracker = new();
   bit                    calm = 1'b0;
   int unsigned           taken_items = 0;
   int unsigned           stall_cycles = 0;

   binary_gap_fill_run_length_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_row               (req_row),
      .req_col               (req_col),
      .req_pixel_set         (req_pixel_set),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_filled            (rsp_filled),
      .rsp_horizontal_filled (rsp_horizontal_filled),
      .rsp_vertical_filled   (rsp_vertical_filled),
      .rsp_query_row         (rsp_query_row),
      .rsp_query_col         (rsp_query_col),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= 11);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_answer({rsp_filled, rsp_horizontal_filled, rsp_vertical_filled,
                               rsp_query_row, rsp_query_col});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("binary_gap_fill_run_length_top regression: fail");
            $finish;
         end
      end
   end

   task automatic send_request(logic kind, int row, int col, logic pixel);
      logic [bgf_pkg::ROW_W-1:0] row_bits;
      logic [bgf_pkg::COL_W-1:0] col_bits;
      row_bits = bgf_pkg::ROW_W'(row);
      col_bits = bgf_pkg::COL_W'(col);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_row       <= row_bits;
      req_col       <= col_bits;
      req_pixel_set <= pixel;
      do
         @(posedge clock);
      while (!req_ready);
      taken_items++;
      tracker.take_request(kind, row_bits, col_bits, pixel);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 4'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drop valid, drain answers, then let trailing writes retire
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_extent();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return bgf_pkg::MAX_COLS;
         2:       return $urandom_range(257, 511);
         3:       return 1;
         default: return $urandom_range(2, 20);
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return 1;
         2:       return 256;
         3:       return 511;
         4:       return $urandom_range(0, 511);
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   function automatic logic [31:0] with_noise(logic [31:0] value);
      if ($urandom_range(0, 3) == 0)
         return {23'($urandom), value[8:0]};
      return value;
   endfunction

   task automatic run_phase(int unsigned count);
      int unsigned               density;
      int unsigned               target;
      logic                      kind;
      logic [bgf_pkg::ROW_W-1:0] row;
      logic [bgf_pkg::COL_W-1:0] col;
      density = $urandom_range(15, 85);
      target  = taken_items + count;
      while (taken_items < target) begin
         kind = ($urandom_range(0, 99) < 45) ? bgf_pkg::KIND_QUERY : bgf_pkg::KIND_WRITE;
         if ($urandom_range(0, 99) < 12) begin
            row = bgf_pkg::ROW_W'($urandom);
            col = bgf_pkg::COL_W'($urandom);
         end else begin
            row = bgf_pkg::ROW_W'($urandom_range(0, tracker.rows_used - 1));
            col = bgf_pkg::COL_W'($urandom_range(0, tracker.cols_used - 1));
         end
         send_request(kind, row, col, $urandom_range(0, 99) < density);
      end
   endtask

   initial begin
      int unsigned phase;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(bgf_pkg::KIND_QUERY, 0, 0, 1'b0);
      send_request(bgf_pkg::KIND_WRITE, 5, 10, 1'b1);
      send_request(bgf_pkg::KIND_WRITE, 5, 20, 1'b1);
      send_request(bgf_pkg::KIND_WRITE, 2, 15, 1'b1);
      send_request(bgf_pkg::KIND_WRITE, 9, 15, 1'b1);
      send_request(bgf_pkg::KIND_QUERY, 5, 15, 1'b0);
      send_request(bgf_pkg::KIND_QUERY, 5, 10, 1'b1);
      send_request(bgf_pkg::KIND_QUERY, 5, 5, 1'b0);
      send_request(bgf_pkg::KIND_QUERY, 5, 25, 1'b0);
      send_request(bgf_pkg::KIND_WRITE, 255, 0, 1'b1);
      send_request(bgf_pkg::KIND_WRITE, 255, 255, 1'b1);
      send_request(bgf_pkg::KIND_QUERY, 255, 128, 1'b0);
      send_request(bgf_pkg::KIND_WRITE, 0, 255, 1'b1);
      send_request(bgf_pkg::KIND_QUERY, 128, 255, 1'b0);
      send_request(bgf_pkg::KIND_QUERY, 255, 255, 1'b0);
      wait_idle();
      csr_write(CSR_HLIMIT, 256);
      csr_write(CSR_VLIMIT, 511);
      send_request(bgf_pkg::KIND_QUERY, 255, 128, 1'b1);
      send_request(bgf_pkg::KIND_QUERY, 128, 255, 1'b1);
      wait_idle();
      csr_write(CSR_HLIMIT, 0);
      csr_write(CSR_VLIMIT, 0);
      send_request(bgf_pkg::KIND_QUERY, 5, 15, 1'b0);
      wait_idle();
      csr_write(CSR_COLS, 0);
      csr_write(CSR_ROWS, 300);
      send_request(bgf_pkg::KIND_WRITE, 3, 4, 1'b1);
      send_request(bgf_pkg::KIND_QUERY, 3, 4, 1'b0);
      send_request(bgf_pkg::KIND_QUERY, 5, 0, 1'b0);
      wait_idle();
      csr_write(CSR_COLS, 256);
      csr_write(CSR_ROWS, 256);
      csr_write(CSR_HLIMIT, 100);
      csr_write(CSR_VLIMIT, 100);
      send_request(bgf_pkg::KIND_WRITE, 255, 0, 1'b0);
      send_request(bgf_pkg::KIND_QUERY, 3, 4, 1'b0);

      phase = 0;
      while (taken_items < ITEM_TARGET) begin
         wait_idle();
         calm = (phase == 2);
         csr_write(CSR_COLS, with_noise(pick_extent()));
         csr_write(CSR_ROWS, with_noise(pick_extent()));
         csr_write(CSR_HLIMIT, with_noise(pick_limit()));
         csr_write(CSR_VLIMIT, with_noise(pick_limit()));
         run_phase($urandom_range(50, 100));
         phase++;
      end
      calm = 1'b0;

      wait_idle();
      if (tracker.errors == 0 && tracker.pending_answers.size() == 0)
         $display("binary_gap_fill_run_length_top regression: pass");
      else
         $display("binary_gap_fill_run_length_top regression: fail");
      $finish;
   end

endmodule
